/* rtl/implicit_list_first_fit_allocator_core_assert.svh */
// Assertion macros for the implicit-list first-fit allocator core.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILFFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILFFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ilffa_pkg.sv */
// Shared types, constants and the microcode table of the allocator core.
// No dependencies; every other RTL file but ilffa_ram imports this package.
`default_nettype none

package ilffa_pkg;

  // Field widths and fixed constants.
  localparam int GRANULE_BYTES     = 8;
  localparam int HEAP_GRANULES_DEF = 4096;
  localparam int REQ_W             = 15;
  localparam int ADDR_W            = 15;
  localparam int NEED_W            = 13;
  localparam int TOP_W             = 16;
  localparam int LIMIT_W           = 16;
  localparam int SUM_W             = 20;
  localparam int CFG_AW            = 3;
  localparam int CFG_DW            = 32;

  localparam logic [TOP_W-1:0]   HEAP_TOP_RST   = 16'd8;
  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 16'd32768;

  // Register word index (paddr bit 2).
  localparam logic REG_HEAP_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_ALLOC,
    ST_OOM,
    ST_FREED,
    ST_IGNORED
  } status_t;

  // Microprogram step addresses.
  typedef enum logic [3:0] {
    UPC_INIT,
    UPC_IDLE,
    UPC_A_START,
    UPC_A_WALK,
    UPC_A_TAKE,
    UPC_A_SPLIT,
    UPC_A_EXT,
    UPC_A_EXT1,
    UPC_A_EXT2,
    UPC_A_OOM,
    UPC_F_CHECK,
    UPC_F_WALK,
    UPC_F_TEST,
    UPC_F_MERGE,
    UPC_F_IGN
  } upc_t;

  // Jump conditions tested by the sequencer.
  typedef enum logic [3:0] {
    C_NONE,
    C_NO_ACCEPT,
    C_ACC_FREE,
    C_G_AT_END,
    C_FIT,
    C_WALK_STOP,
    C_NO_SPLIT,
    C_OOM,
    C_BAD_ADDR,
    C_F_STOP0,
    C_LEN_ZERO,
    C_F_STOP,
    C_F_MISS
  } cond_t;

  typedef enum logic [2:0] {
    AS_ZERO,
    AS_G,
    AS_G_NEED,
    AS_END,
    AS_END_NEED,
    AS_WALK
  } addr_sel_t;

  typedef enum logic [2:0] {
    WD_NONE,
    WD_ENDMARK,
    WD_USED,
    WD_REMAIN,
    WD_MERGED
  } wdata_sel_t;

  typedef enum logic [1:0] {
    G_HOLD,
    G_CLEAR,
    G_ADV
  } g_op_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ALLOC_G,
    EM_ALLOC_END,
    EM_OOM,
    EM_FREED,
    EM_IGNORED
  } emit_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic       take;
    logic       rd;
    addr_sel_t  asel;
    wdata_sel_t wsel;
    g_op_t      gop;
    logic       hdr_ld;
    logic       top_ld;
    emit_t      emit;
    cond_t      cond_a;
    upc_t       tgt_a;
    cond_t      cond_b;
    upc_t       tgt_b;
    upc_t       nxt;
  } ucw_t;

  // Status flags from the datapath, one per jump condition.
  typedef struct packed {
    logic no_accept;
    logic acc_free;
    logic g_at_end;
    logic fit;
    logic walk_stop;
    logic no_split;
    logic oom;
    logic bad_addr;
    logic f_stop0;
    logic len_zero;
    logic f_stop;
    logic f_miss;
  } flags_t;

  localparam ucw_t UCW_NOP = '{
    take: 1'b0, rd: 1'b0, asel: AS_ZERO, wsel: WD_NONE, gop: G_HOLD,
    hdr_ld: 1'b0, top_ld: 1'b0, emit: EM_NONE,
    cond_a: C_NONE, tgt_a: UPC_IDLE, cond_b: C_NONE, tgt_b: UPC_IDLE,
    nxt: UPC_IDLE
  };

  // The microprogram. Jump A has priority over jump B, then nxt.
  function automatic ucw_t ucode_word(upc_t pc);
    ucw_t w;
    w = UCW_NOP;
    unique case (pc)
      // Write the end marker into granule 0 once after reset.
      UPC_INIT: begin
        w.wsel = WD_ENDMARK;
      end
      // Wait for a request and dispatch on the operation.
      UPC_IDLE: begin
        w.take   = 1'b1;
        w.gop    = G_CLEAR;
        w.cond_a = C_NO_ACCEPT;
        w.tgt_a  = UPC_IDLE;
        w.cond_b = C_ACC_FREE;
        w.tgt_b  = UPC_F_CHECK;
        w.nxt    = UPC_A_START;
      end
      UPC_A_START: begin
        w.rd     = 1'b1;
        w.asel   = AS_G;
        w.cond_a = C_G_AT_END;
        w.tgt_a  = UPC_A_EXT;
        w.nxt    = UPC_A_WALK;
      end
      // One header per cycle; the next header read is issued speculatively.
      UPC_A_WALK: begin
        w.rd     = 1'b1;
        w.asel   = AS_WALK;
        w.hdr_ld = 1'b1;
        w.gop    = G_ADV;
        w.cond_a = C_FIT;
        w.tgt_a  = UPC_A_TAKE;
        w.cond_b = C_WALK_STOP;
        w.tgt_b  = UPC_A_EXT;
        w.nxt    = UPC_A_WALK;
      end
      UPC_A_TAKE: begin
        w.asel   = AS_G;
        w.wsel   = WD_USED;
        w.emit   = EM_ALLOC_G;
        w.cond_a = C_NO_SPLIT;
        w.tgt_a  = UPC_IDLE;
        w.nxt    = UPC_A_SPLIT;
      end
      UPC_A_SPLIT: begin
        w.asel = AS_G_NEED;
        w.wsel = WD_REMAIN;
      end
      UPC_A_EXT: begin
        w.cond_a = C_OOM;
        w.tgt_a  = UPC_A_OOM;
        w.nxt    = UPC_A_EXT1;
      end
      UPC_A_EXT1: begin
        w.asel = AS_END;
        w.wsel = WD_USED;
        w.emit = EM_ALLOC_END;
        w.nxt  = UPC_A_EXT2;
      end
      UPC_A_EXT2: begin
        w.asel   = AS_END_NEED;
        w.wsel   = WD_ENDMARK;
        w.top_ld = 1'b1;
      end
      UPC_A_OOM: begin
        w.emit = EM_OOM;
      end
      UPC_F_CHECK: begin
        w.rd     = 1'b1;
        w.asel   = AS_G;
        w.cond_a = C_BAD_ADDR;
        w.tgt_a  = UPC_F_IGN;
        w.cond_b = C_F_STOP0;
        w.tgt_b  = UPC_F_TEST;
        w.nxt    = UPC_F_WALK;
      end
      UPC_F_WALK: begin
        w.rd     = 1'b1;
        w.asel   = AS_WALK;
        w.gop    = G_ADV;
        w.cond_a = C_LEN_ZERO;
        w.tgt_a  = UPC_F_TEST;
        w.cond_b = C_F_STOP;
        w.tgt_b  = UPC_F_TEST;
        w.nxt    = UPC_F_WALK;
      end
      // Header of the target is on the read port; fetch its successor.
      UPC_F_TEST: begin
        w.rd     = 1'b1;
        w.asel   = AS_WALK;
        w.hdr_ld = 1'b1;
        w.cond_a = C_F_MISS;
        w.tgt_a  = UPC_F_IGN;
        w.nxt    = UPC_F_MERGE;
      end
      UPC_F_MERGE: begin
        w.asel = AS_G;
        w.wsel = WD_MERGED;
        w.emit = EM_FREED;
      end
      UPC_F_IGN: begin
        w.emit = EM_IGNORED;
      end
      default: w = UCW_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/ilffa_if.sv */
// Request and response channel interfaces of the allocator core.
// Depends on ilffa_pkg for the payload widths.
`default_nettype none

interface ilffa_req_if import ilffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [REQ_W-1:0]  req_size;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, op, req_size, free_addr, input ready);
  modport sink (input valid, op, req_size, free_addr, output ready);
endinterface

interface ilffa_rsp_if import ilffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, status, block_addr, input ready);
  modport sink (input valid, status, block_addr, output ready);
endinterface

`default_nettype wire

/* rtl/ilffa_ram.sv */
// Generic single-port RAM with registered read data.
// Standalone; used for the header store.
`default_nettype none

module ilffa_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read share one address; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/ilffa_seq.sv */
// Microcode sequencer: step counter, control word lookup and branching.
// Depends on ilffa_pkg for the control word, conditions and the microprogram.
`default_nettype none

module ilffa_seq import ilffa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  input  logic   stall,
  output ucw_t   ctl,
  output logic   jump_a
);

  upc_t pc_r;
  upc_t pc_nxt;
  logic jump_b;

  // Select the flag that a condition code names.
  function automatic logic cond_hit(cond_t c, flags_t f);
    logic hit;
    case (c)
      C_NO_ACCEPT: hit = f.no_accept;
      C_ACC_FREE:  hit = f.acc_free;
      C_G_AT_END:  hit = f.g_at_end;
      C_FIT:       hit = f.fit;
      C_WALK_STOP: hit = f.walk_stop;
      C_NO_SPLIT:  hit = f.no_split;
      C_OOM:       hit = f.oom;
      C_BAD_ADDR:  hit = f.bad_addr;
      C_F_STOP0:   hit = f.f_stop0;
      C_LEN_ZERO:  hit = f.len_zero;
      C_F_STOP:    hit = f.f_stop;
      C_F_MISS:    hit = f.f_miss;
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

  assign ctl = ucode_word(pc_r);

  // Next step: hold on a stall, else jump A, jump B or fall through.
  always_comb begin
    jump_a = cond_hit(ctl.cond_a, flags);
    jump_b = cond_hit(ctl.cond_b, flags);
    if (stall) begin
      pc_nxt = pc_r;
    end else if (jump_a) begin
      pc_nxt = ctl.tgt_a;
    end else if (jump_b) begin
      pc_nxt = ctl.tgt_b;
    end else begin
      pc_nxt = ctl.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_INIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ilffa_dp.sv */
// Datapath of the allocator: walk registers, header store, heap top and result register.
// Depends on ilffa_pkg and instantiates ilffa_ram.
`default_nettype none

module ilffa_dp import ilffa_pkg::*; #(
  parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ucw_t               ctl,
  input  logic               jump_a,
  output flags_t             flags,
  output logic               stall,
  input  logic               in_valid,
  input  logic               in_op,
  input  logic [REQ_W-1:0]   in_req_size,
  input  logic [ADDR_W-1:0]  in_free_addr,
  input  logic [LIMIT_W-1:0] heap_limit,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [ADDR_W-1:0]  out_block_addr
);

  localparam int GW = $clog2(HEAP_GRANULES);
  localparam int HW = GW + 1;
  localparam int CW = ((GW > NEED_W) ? GW : NEED_W) + 2;
  localparam logic [SUM_W-1:0] CAP_BYTES = SUM_W'(HEAP_GRANULES * GRANULE_BYTES);

  logic [NEED_W-1:0]  need_r;
  logic [ADDR_W-1:0]  faddr_r;
  logic [GW-1:0]      g_r;
  logic [HW-1:0]      hdr_r;
  logic [GW-1:0]      end_r;
  logic [TOP_W-1:0]   top_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;

  logic [HW-1:0]      rdata;
  logic [HW-1:0]      wdata;
  logic [GW-1:0]      mem_addr;
  logic               mem_we;
  logic               mem_re;
  logic               accept;
  logic               emit_fire;
  logic [TOP_W-1:0]   round_sum;
  logic [NEED_W-1:0]  need_in;
  logic [GW-1:0]      need_g;
  logic [GW-1:0]      rd_len;
  logic               rd_alloc;
  logic [GW-1:0]      hd_len;
  logic [GW:0]        walk_sum;
  logic [GW:0]        next_g;
  logic [GW-1:0]      merged;
  logic [SUM_W-1:0]   top_sum;
  logic [CW-1:0]      target;
  logic [ADDR_W-1:0]  addr_g;
  logic [ADDR_W-1:0]  addr_end;

  // Request decode: need = ceil((req + 4) / 8) granules.
  assign round_sum = TOP_W'(in_req_size) + TOP_W'(4 + GRANULE_BYTES - 1);
  assign need_in   = round_sum[TOP_W-1:3];
  assign accept    = ctl.take && in_valid;

  // Header fields and walk arithmetic.
  assign rd_len   = rdata[HW-1:1];
  assign rd_alloc = rdata[0];
  assign hd_len   = hdr_r[HW-1:1];
  assign need_g   = GW'(need_r);
  assign walk_sum = {1'b0, g_r} + {1'b0, rd_len};
  assign next_g   = {1'b0, g_r} + {1'b0, hd_len};
  assign merged   = (next_g != {1'b0, end_r} && !rd_alloc) ? hd_len + rd_len : hd_len;
  assign top_sum  = SUM_W'(top_r) + SUM_W'({need_r, 3'b000});
  assign target   = CW'(faddr_r[ADDR_W-1:3]) - CW'(1);
  assign addr_g   = ADDR_W'({1'b0, g_r, 3'b000} + (GW + 4)'(GRANULE_BYTES));
  assign addr_end = ADDR_W'({1'b0, end_r, 3'b000} + (GW + 4)'(GRANULE_BYTES));

  // Condition flags for the sequencer.
  always_comb begin
    flags.no_accept = !in_valid;
    flags.acc_free  = in_op;
    flags.g_at_end  = (g_r == end_r);
    flags.fit       = !rd_alloc && (CW'(rd_len) >= CW'(need_r));
    flags.walk_stop = (rd_len == '0) || (walk_sum == {1'b0, end_r});
    flags.no_split  = (CW'(hd_len) == CW'(need_r));
    flags.oom       = (top_sum > SUM_W'(heap_limit)) || (top_sum > CAP_BYTES) ||
                      (CW'(end_r) + CW'(need_r) >= CW'(HEAP_GRANULES));
    flags.bad_addr  = (faddr_r[ADDR_W-1:3] == '0) || (faddr_r[2:0] != 3'b000);
    flags.f_stop0   = (CW'(g_r) >= CW'(end_r)) || (CW'(g_r) >= target);
    flags.len_zero  = (rd_len == '0);
    flags.f_stop    = (CW'(walk_sum) >= CW'(end_r)) || (CW'(walk_sum) >= target);
    flags.f_miss    = (CW'(g_r) != target) || (g_r >= end_r) || !rd_alloc;
  end

  // A step that emits waits while the result register is still full.
  assign stall     = (ctl.emit != EM_NONE) && out_valid_r && !out_ready;
  assign emit_fire = (ctl.emit != EM_NONE) && !stall;

  // Header store address and write data.
  always_comb begin
    case (ctl.asel)
      AS_G:        mem_addr = g_r;
      AS_G_NEED:   mem_addr = g_r + need_g;
      AS_END:      mem_addr = end_r;
      AS_END_NEED: mem_addr = end_r + need_g;
      AS_WALK:     mem_addr = walk_sum[GW-1:0];
      default:     mem_addr = '0;
    endcase
    case (ctl.wsel)
      WD_ENDMARK: wdata = HW'(1);
      WD_USED:    wdata = {need_g, 1'b1};
      WD_REMAIN:  wdata = {hd_len - need_g, 1'b0};
      WD_MERGED:  wdata = {merged, 1'b0};
      default:    wdata = '0;
    endcase
  end

  assign mem_we = (ctl.wsel != WD_NONE) && !stall;
  assign mem_re = ctl.rd && !stall;

  ilffa_ram #(
    .WIDTH (HW),
    .DEPTH (HEAP_GRANULES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Control state: heap extent and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r       <= '0;
      top_r       <= HEAP_TOP_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.top_ld && !stall) begin
        end_r <= end_r + need_g;
        top_r <= top_r + {need_r, 3'b000};
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      need_r  <= need_in;
      faddr_r <= in_free_addr;
    end
    if (!stall) begin
      case (ctl.gop)
        G_CLEAR: g_r <= '0;
        G_ADV: begin
          if (!jump_a) begin
            g_r <= walk_sum[GW-1:0];
          end
        end
        default: g_r <= g_r;
      endcase
      if (ctl.hdr_ld) begin
        hdr_r <= rdata;
      end
    end
    if (emit_fire) begin
      case (ctl.emit)
        EM_ALLOC_G: begin
          out_status_r <= ST_ALLOC;
          out_addr_r   <= addr_g;
        end
        EM_ALLOC_END: begin
          out_status_r <= ST_ALLOC;
          out_addr_r   <= addr_end;
        end
        EM_OOM: begin
          out_status_r <= ST_OOM;
          out_addr_r   <= '0;
        end
        EM_FREED: begin
          out_status_r <= ST_FREED;
          out_addr_r   <= '0;
        end
        default: begin
          out_status_r <= ST_IGNORED;
          out_addr_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_block_addr = out_addr_r;

endmodule

`default_nettype wire

/* rtl/implicit_list_first_fit_allocator_core.sv */
// Usage:
// Requests arrive on in_ch (op 0 allocate req_size bytes, op 1 free free_addr) and
// each one yields exactly one response on out_ch (status and payload offset).
// A microprogram in a small table sequences a datapath around a single-port
// header store of HEAP_GRANULES entries with registered read data.
// Allocate walks the headers and takes the first fit, else extends the heap
// at the end marker. Free walks to the target header, and a malformed address
// is rejected before any walk. The next request is taken in the idle step
// after the result, or after the remainder header or the new end marker is
// written for a split or an extension. The walk visits one header per cycle,
// bounded by the single RAM port.
// After reset the block writes the end marker into granule 0 in its init
// step, then raises in_ch.ready; the heap is empty and the limit is 32768 bytes.
// The result sits in an output register, so a new request is taken while the
// previous result waits; if out_ch stalls, the next result waits in its
// emitting step until the register drains. The heap limit register is written
// through the cfg_ port at byte address 0, only while no request is in flight;
// the user must keep to this, as the block itself does not enforce it.
`default_nettype none

`include "implicit_list_first_fit_allocator_core_assert.svh"

module implicit_list_first_fit_allocator_core import ilffa_pkg::*; #(
  parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ilffa_req_if.sink         in_ch,
  ilffa_rsp_if.source       out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [LIMIT_W-1:0] heap_limit_r;
  logic               cfg_wr;
  ucw_t               ctl;
  flags_t             flags;
  logic               jump_a;
  logic               stall;
  logic               emit_fire;
  logic               in_accept;
  logic               pending_r;

  // Configuration port: one register, no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_HEAP_LIMIT) ? CFG_DW'(heap_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= HEAP_LIMIT_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_HEAP_LIMIT) begin
      heap_limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  assign in_ch.ready = ctl.take;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign emit_fire   = (ctl.emit != EM_NONE) && !stall;

  ilffa_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .flags  (flags),
    .stall  (stall),
    .ctl    (ctl),
    .jump_a (jump_a)
  );

  ilffa_dp #(
    .HEAP_GRANULES (HEAP_GRANULES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .jump_a         (jump_a),
    .flags          (flags),
    .stall          (stall),
    .in_valid       (in_ch.valid),
    .in_op          (in_ch.op),
    .in_req_size    (in_ch.req_size),
    .in_free_addr   (in_ch.free_addr),
    .heap_limit     (heap_limit_r),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_block_addr (out_ch.block_addr)
  );

  // Tracks a request that has been taken but whose result is not yet produced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else if (in_accept) begin
      pending_r <= 1'b1;
    end else if (emit_fire) begin
      pending_r <= 1'b0;
    end
  end

  // A result is only produced for a request in flight.
  `ILFFA_ASSERT_SAME(a_emit_needs_request, emit_fire, pending_r, "result without a request")
  // No new request is taken before the previous one has produced its result.
  `ILFFA_ASSERT_SAME(a_accept_when_done, in_accept, !pending_r, "request taken while busy")
  // Once a request is taken, the next cycle shows it pending and ready low.
  `ILFFA_ASSERT_NEXT(a_accept_then_busy, in_accept, pending_r && !in_ch.ready, "ready after accept")
  // Only a successful allocation carries a nonzero block address.
  `ILFFA_ASSERT_SAME(a_addr_zero, out_ch.valid && out_ch.status != ST_ALLOC, out_ch.block_addr == '0, "nonzero address")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the implicit-list first-fit allocator core.
// Depends on ilffa_pkg and the ilffa_req_if / ilffa_rsp_if channel interfaces.

module tb_top import ilffa_pkg::*; ();

  localparam int NGRAN = HEAP_GRANULES_DEF;
  localparam int HDR_W = NEED_W;
  localparam int LEN_W = NEED_W - 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_AW-1:0] LIMIT_ADDR  = {REG_HEAP_LIMIT, 2'b00};
  localparam logic [CFG_AW-1:0] UNUSED_ADDR = 3'd4;

  typedef struct packed {
    logic              op;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] free_addr;
  } alloc_req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] block_addr;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  ilffa_req_if req_ch ();
  ilffa_rsp_if rsp_ch ();

  implicit_list_first_fit_allocator_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the heap: headers, heap size and limit.
  logic [HDR_W-1:0]   hdr_model [NGRAN];
  logic [TOP_W-1:0]   model_heap_top;
  logic [LIMIT_W-1:0] model_limit;
  logic [ADDR_W-1:0]  live_blocks[$];

  alloc_req_t   pending_reqs[$];
  heap_result_t expected_results[$];
  alloc_req_t   held_req;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           mismatches = 0;

  always #5 clk = ~clk;

  // First-fit allocate: walk the headers, split a fitting free block, else extend.
  function automatic heap_result_t predict_alloc(input logic [REQ_W-1:0] req);
    heap_result_t r;
    int need;
    int endg;
    int g;
    int steps;
    int len;
    int lim;
    logic [HDR_W-1:0] h;
    r.status = ST_OOM;
    r.block_addr = '0;
    need = (int'(req) + 4 + GRANULE_BYTES - 1) / GRANULE_BYTES;
    endg = int'(model_heap_top) / GRANULE_BYTES - 1;
    g = 0;
    steps = 0;
    while (g != endg && g < NGRAN && steps < NGRAN) begin
      h = hdr_model[g];
      len = int'(h[HDR_W-1:1]);
      if (!h[0] && len >= need) begin
        hdr_model[g] = {LEN_W'(need), 1'b1};
        if (len > need && g + need < NGRAN)
          hdr_model[g + need] = {LEN_W'(len - need), 1'b0};
        r.status = ST_ALLOC;
        r.block_addr = ADDR_W'(GRANULE_BYTES * g + GRANULE_BYTES);
        live_blocks.push_back(r.block_addr);
        return r;
      end
      if (len == 0)
        break;
      g += len;
      steps++;
    end
    lim = (int'(model_limit) < NGRAN * GRANULE_BYTES) ? int'(model_limit)
                                                      : NGRAN * GRANULE_BYTES;
    if (int'(model_heap_top) + need * GRANULE_BYTES > lim || endg + need >= NGRAN)
      return r;
    hdr_model[endg] = {LEN_W'(need), 1'b1};
    hdr_model[endg + need] = {LEN_W'(0), 1'b1};
    model_heap_top = model_heap_top + TOP_W'(need * GRANULE_BYTES);
    r.status = ST_ALLOC;
    r.block_addr = ADDR_W'(GRANULE_BYTES * endg + GRANULE_BYTES);
    live_blocks.push_back(r.block_addr);
    return r;
  endfunction

  // Free: locate the block by walking, clear its bit, merge with a free successor.
  function automatic heap_result_t predict_free(input logic [ADDR_W-1:0] addr);
    heap_result_t r;
    int endg;
    int target;
    int g;
    int steps;
    int len;
    int nxt;
    logic [HDR_W-1:0] h;
    r.status = ST_IGNORED;
    r.block_addr = '0;
    if (addr < GRANULE_BYTES || addr[2:0] != 3'd0)
      return r;
    target = int'(addr) / GRANULE_BYTES - 1;
    endg = int'(model_heap_top) / GRANULE_BYTES - 1;
    g = 0;
    steps = 0;
    while (g < endg && g < target && g < NGRAN && steps < NGRAN) begin
      len = int'(hdr_model[g][HDR_W-1:1]);
      if (len == 0)
        break;
      g += len;
      steps++;
    end
    if (g != target || g >= endg || g >= NGRAN)
      return r;
    h = hdr_model[g];
    if (!h[0])
      return r;
    len = int'(h[HDR_W-1:1]);
    nxt = g + len;
    if (nxt != endg && nxt < NGRAN && !hdr_model[nxt][0])
      len += int'(hdr_model[nxt][HDR_W-1:1]);
    hdr_model[g] = {LEN_W'(len), 1'b0};
    r.status = ST_FREED;
    foreach (live_blocks[i]) begin
      if (live_blocks[i] == addr) begin
        live_blocks.delete(i);
        break;
      end
    end
    return r;
  endfunction

  // Request driver: present the next pending transaction, with random gaps.
  always @(posedge clk) begin
    alloc_req_t nxt_req;
    heap_result_t res;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (held_req.op == OP_ALLOC)
          res = predict_alloc(held_req.req_size);
        else
          res = predict_free(held_req.free_addr);
        expected_results.push_back(res);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_req = pending_reqs.pop_front();
          held_req = nxt_req;
          req_ch.valid <= 1'b1;
          req_ch.op <= nxt_req.op;
          req_ch.req_size <= nxt_req.req_size;
          req_ch.free_addr <= nxt_req.free_addr;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response sink: random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Response monitor: compare each transaction with the oldest expectation.
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("status: no response expected, actual %0d (block_addr %0d)",
               rsp_ch.status, rsp_ch.block_addr);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.block_addr !== want.block_addr) begin
          $error("block_addr: expected %0d, actual %0d", want.block_addr,
                 rsp_ch.block_addr);
          mismatches++;
        end
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr[CFG_AW-1:2] == REG_HEAP_LIMIT)
      model_limit = data[LIMIT_W-1:0];
  endtask

  // Wait until every request is sent and answered, then let trailing writes settle.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_req(input logic op, input int size, input int addr);
    alloc_req_t it;
    it.op = op;
    it.req_size = REQ_W'(size);
    it.free_addr = ADDR_W'(addr);
    pending_reqs.push_back(it);
  endtask

  // One random phase: mostly allocations and frees of live blocks, some bad frees.
  task automatic run_phase(input int limit, input int count, input int send_pct,
                           input int recv_pct, input bit big);
    alloc_req_t it;
    int done;
    int r;
    int s;
    wait_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    cfg_write(LIMIT_ADDR, CFG_DW'(limit));
    done = 0;
    while (done < count) begin
      while (pending_reqs.size() >= 4)
        @(negedge clk);
      it.req_size = REQ_W'($urandom);
      it.free_addr = ADDR_W'($urandom);
      r = $urandom_range(99);
      if (r < 55 || (r < 88 && live_blocks.size() == 0)) begin
        it.op = OP_ALLOC;
        s = $urandom_range(99);
        if (s < 70)
          it.req_size = REQ_W'($urandom_range(0, 48));
        else if (s < (big ? 85 : 95))
          it.req_size = REQ_W'($urandom_range(49, 600));
        else if (s < 98)
          it.req_size = REQ_W'($urandom_range(601, 4000));
        done++;
      end else if (r < 88) begin
        it.op = OP_FREE;
        it.free_addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
        done++;
      end else begin
        // Bad frees: random offset, end marker payload, or inside a live block.
        it.op = OP_FREE;
        s = $urandom_range(3);
        if (s == 1)
          it.free_addr = ADDR_W'(model_heap_top);
        else if (s >= 2 && live_blocks.size() != 0)
          it.free_addr = live_blocks[$urandom_range(live_blocks.size() - 1)]
                         + ADDR_W'(s == 2 ? 8 : 4);
        done++;
      end
      pending_reqs.push_back(it);
    end
  endtask

  // Stimulus: reset, directed corner cases, then random phases over several limits.
  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.req_size = '0;
    req_ch.free_addr = '0;
    rsp_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    foreach (hdr_model[i]) hdr_model[i] = '0;
    hdr_model[0] = {LEN_W'(0), 1'b1};
    model_heap_top = HEAP_TOP_RST;
    model_limit = HEAP_LIMIT_RST;
    send_idle_pct = 10;
    recv_idle_pct = 71;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest limit: room for exactly one granule-sized block.
    cfg_write(LIMIT_ADDR, CFG_DW'(16));
    push_req(OP_ALLOC, 0, 0);      // zero-byte request takes one granule
    push_req(OP_ALLOC, 1, 0);      // extension past the limit
    push_req(OP_FREE, 0, 8);
    push_req(OP_FREE, 0, 8);       // double free
    push_req(OP_ALLOC, 4, 0);      // exact fit, no split
    push_req(OP_FREE, 0, 16);      // end marker payload
    push_req(OP_FREE, 0, 0);       // below the first payload
    push_req(OP_FREE, 0, 12);      // not granule aligned
    push_req(OP_FREE, 32767, 32767);
    wait_drained();

    // Largest limit: splits, merges with the next block, bad addresses.
    cfg_write(LIMIT_ADDR, CFG_DW'(32768));
    push_req(OP_ALLOC, 32767, 0);  // needs more than the whole heap
    push_req(OP_ALLOC, 20, 0);
    push_req(OP_ALLOC, 60, 0);
    push_req(OP_ALLOC, 100, 0);
    push_req(OP_FREE, 0, 40);
    push_req(OP_FREE, 0, 16);      // merges with the free block after it
    push_req(OP_ALLOC, 10, 0);     // fit with remainder split off
    push_req(OP_FREE, 0, 48);      // inside a block
    push_req(OP_FREE, 0, 32760);   // past the end marker
    push_req(OP_ALLOC, 0, 0);
    push_req(OP_FREE, 0, 104);     // successor is the end marker
    push_req(OP_FREE, 0, 16);
    push_req(OP_FREE, 0, 32);

    run_phase(256, 260, 10, 71, 1'b0);
    run_phase(1024, 300, 10, 71, 1'b0);
    wait_drained();
    cfg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
    run_phase(16, 150, 71, 10, 1'b0);
    run_phase(4096, 350, 71, 10, 1'b0);
    run_phase(2048, 150, 0, 0, 1'b0);
    run_phase(32768, 370, 0, 0, 1'b1);

    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1_000_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ilffa_pkg.sv
rtl/ilffa_if.sv
rtl/ilffa_ram.sv
rtl/ilffa_seq.sv
rtl/ilffa_dp.sv
rtl/implicit_list_first_fit_allocator_core.sv
tb/sv/tb_top.sv
